@@ hw/rtl/mts_pkg.sv @@
// Shared types and constants for the min tracking stack.
`timescale 1ns / 1ps
package mts_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

@@ hw/rtl/mts_in_if.sv @@
// Input channel carrying push and pop requests.
`timescale 1ns / 1ps
interface mts_in_if;
    logic                valid;
    logic                ready;
    logic                mode;
    logic signed [31:0]  push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

@@ hw/rtl/mts_out_if.sv @@
// Output channel carrying the stack state after each request.
`timescale 1ns / 1ps
interface mts_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  top_value;
    logic signed [31:0]  min_value;
    logic [4:0]          entry_count;
    logic                is_empty;
    logic [1:0]          status;

    modport source (output valid, output top_value, output min_value, output entry_count,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input entry_count,
                    input is_empty, input status, output ready);
endinterface

@@ hw/rtl/min_tracking_stack.sv @@
// Top level of the bounded stack that tracks its running minimum.
`timescale 1ns / 1ps
// The block holds up to DEPTH signed 32-bit values in a row of shifting cells, with a
// second row that keeps the running minima, so the top of each row always sits in its
// first cell. Every beat on the input is one push or pop, and it yields one beat on the
// output with the new top, minimum, count and status; top and minimum read as -1 when the
// stack is empty. A request passes through the cell rows straight into the output
// register, and a new request is taken in every cycle in which the output register is
// free or is being emptied, so the sustained rate is one request per cycle.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mts_in_if.sink    i_in,
    mts_out_if.source o_out
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_min_count;
    logic [CW-1:0] n_min_count;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_top;
    logic signed [DATA_W-1:0] r_out_min;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_empty;
    t_status                  r_out_status;

    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    logic       w_is_pop;
    t_shift_ctl w_val_ctl;
    t_shift_ctl w_min_ctl;
    t_status    w_status;

    logic signed [DATA_W-1:0] w_val_top;
    logic signed [DATA_W-1:0] w_val_next;
    logic signed [DATA_W-1:0] w_min_top;
    logic signed [DATA_W-1:0] w_min_next;
    logic signed [DATA_W-1:0] w_res_top;
    logic signed [DATA_W-1:0] w_res_min;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_is_pop   = (t_mode'(i_in.mode) == MODE_POP);

    always_comb begin
        w_val_ctl.push = w_accept && !w_is_pop && !w_full;
        w_val_ctl.pop  = w_accept && w_is_pop && !w_empty;
        w_min_ctl.push = w_val_ctl.push && (r_min_count != CW'(DEPTH))
                         && ((r_min_count == '0) || (i_in.push_value <= w_min_top));
        w_min_ctl.pop  = w_val_ctl.pop && (r_min_count != '0) && (w_val_top == w_min_top);

        n_count = r_count;
        if (w_val_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (w_val_ctl.pop) begin
            n_count = r_count - CW'(1);
        end

        n_min_count = r_min_count;
        if (w_min_ctl.push) begin
            n_min_count = r_min_count + CW'(1);
        end else if (w_min_ctl.pop) begin
            n_min_count = r_min_count - CW'(1);
        end

        w_status = ST_OK;
        if (!w_is_pop && w_full) begin
            w_status = ST_FULL;
        end else if (w_is_pop && w_empty) begin
            w_status = ST_EMPTY;
        end

        w_res_top = (n_count != '0) ? w_val_next : EMPTY_VALUE;
        w_res_min = ((n_count != '0) && (n_min_count != '0)) ? w_min_next : EMPTY_VALUE;
    end

    mts_chain #(.DEPTH(DEPTH)) u_val_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_val_ctl),
        .i_new_value (i_in.push_value),
        .o_top       (w_val_top),
        .o_next_top  (w_val_next)
    );

    mts_chain #(.DEPTH(DEPTH)) u_min_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_min_ctl),
        .i_new_value (i_in.push_value),
        .o_top       (w_min_top),
        .o_next_top  (w_min_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_min_count <= n_min_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_top    <= w_res_top;
            r_out_min    <= w_res_min;
            r_out_count  <= COUNT_W'(n_count);
            r_out_empty  <= (n_count == '0);
            r_out_status <= w_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.top_value   = r_out_top;
    assign o_out.min_value   = r_out_min;
    assign o_out.entry_count = r_out_count;
    assign o_out.is_empty    = r_out_empty;
    assign o_out.status      = r_out_status;

    a_min_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_count <= r_count)
        else $error("Min row holds more entries than the stack.");

    a_min_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min_count != '0))
        else $error("Stack holds values but the min row is empty.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_val_ctl.push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("Accepted push did not grow the stack.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |->
            ((r_out_top == EMPTY_VALUE) && (r_out_min == EMPTY_VALUE)))
        else $error("Empty result does not show -1 for top and minimum.");

endmodule

@@ hw/rtl/mts_cell.sv @@
// One stack cell that takes its neighbor's value on a shift.
`timescale 1ns / 1ps
module mts_cell
    import mts_pkg::*;
(
    input  logic                     i_clk,
    input  t_shift_ctl               i_ctl,
    input  logic signed [DATA_W-1:0] i_from_above,
    input  logic signed [DATA_W-1:0] i_from_below,
    output logic signed [DATA_W-1:0] o_value,
    output logic signed [DATA_W-1:0] o_next
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        if (i_ctl.push) begin
            n_value = i_from_above;
        end else if (i_ctl.pop) begin
            n_value = i_from_below;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_next  = n_value;

endmodule

@@ hw/rtl/mts_chain.sv @@
// Row of stack cells with the top entry in cell zero.
`timescale 1ns / 1ps
module mts_chain
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  t_shift_ctl               i_ctl,
    input  logic signed [DATA_W-1:0] i_new_value,
    output logic signed [DATA_W-1:0] o_top,
    output logic signed [DATA_W-1:0] o_next_top
);

    logic signed [DATA_W-1:0] w_value [DEPTH];
    logic signed [DATA_W-1:0] w_next  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_above;
        logic signed [DATA_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_new_value;
        end else begin : g_mid_above
            assign w_above = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_below = w_value[g];
        end else begin : g_mid_below
            assign w_below = w_value[g+1];
        end

        mts_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_value      (w_value[g]),
            .o_next       (w_next[g])
        );
    end

    assign o_top      = w_value[0];
    assign o_next_top = w_next[0];

endmodule
